// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted.
`define DMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dms assertion failed");

// Clocked check that also holds during reset.
`define DMS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dms assertion failed");

`else

`define DMS_ASSERT(lbl, clk, rst_n, prop)
`define DMS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/dms_pkg.sv =====
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants of the diagnostic mode scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int NOW_W    = 32;
    localparam int PERIOD_W = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] VOLTAGE_PERIOD_RST = 16'd100;
    localparam logic [PERIOD_W-1:0] TEMP_PERIOD_RST    = 16'd1000;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_PERIOD    = 1'b1;

    // Mode codes; MODE_CURRENT also marks an empty queue slot
    typedef enum logic [MODE_W-1:0] {
        MODE_CURRENT = 2'd0,
        MODE_VOLTAGE = 2'd1,
        MODE_TEMP    = 2'd2
    } mode_t;

    // Insertion status passed from cell to cell along the queue
    typedef struct packed {
        logic v_done;
        logic t_done;
    } chain_t;

endpackage

`default_nettype wire

// ===== rtl/dms_req_if.sv =====
// ----------------------------------------------------------------------------
// dms_req_if
// Input channel: one loop iteration time stamp per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_req_if;
    logic                           valid;
    logic                           ready;
    logic [dms_pkg::NOW_W-1:0]      now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/dms_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dms_rsp_if
// Output channel: selected mode and timer flags per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [dms_pkg::MODE_W-1:0]     mode;
    logic                           voltage_due;
    logic                           temp_due;

    modport source (output valid, output mode, output voltage_due, output temp_due,
                    input ready);
    modport sink   (input valid, input mode, input voltage_due, input temp_due,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/dms_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dms_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dms_pkg::CFG_IDX_W-1:0]  index;
    logic [dms_pkg::PERIOD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dms_cell.sv =====
// ----------------------------------------------------------------------------
// dms_cell
// One slot of the pending request queue: insert, dedupe, shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                pop,
    input  wire logic                v_req,
    input  wire logic                t_req,
    input  wire dms_pkg::chain_t     chain_in,
    output dms_pkg::chain_t          chain_out,
    input  wire dms_pkg::mode_t      right_val,
    output dms_pkg::mode_t           post_val,
    output dms_pkg::mode_t           entry
);

    dms_pkg::mode_t entry_reg;
    dms_pkg::mode_t entry_next;
    dms_pkg::mode_t after_v;

    always_comb
    begin
        // voltage insertion
        after_v = entry_reg;
        if (v_req && !chain_in.v_done && entry_reg == dms_pkg::MODE_CURRENT)
        begin
            after_v = dms_pkg::MODE_VOLTAGE;
        end
        chain_out.v_done = chain_in.v_done || !v_req
                         || entry_reg == dms_pkg::MODE_CURRENT
                         || entry_reg == dms_pkg::MODE_VOLTAGE;

        // temperature insertion, sees the slot after the voltage step
        post_val = after_v;
        if (t_req && !chain_in.t_done && after_v == dms_pkg::MODE_CURRENT)
        begin
            post_val = dms_pkg::MODE_TEMP;
        end
        chain_out.t_done = chain_in.t_done || !t_req
                         || after_v == dms_pkg::MODE_CURRENT
                         || after_v == dms_pkg::MODE_TEMP;

        entry_next = pop ? right_val : post_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= dms_pkg::MODE_CURRENT;
        end
        else if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/dms_timer.sv =====
// ----------------------------------------------------------------------------
// dms_timer
// Period register and time stamp; flags when the period has elapsed.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_timer #(
    parameter logic [dms_pkg::PERIOD_W-1:0] PERIOD_RST = dms_pkg::VOLTAGE_PERIOD_RST
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dms_pkg::PERIOD_W-1:0]  cfg_data,
    input  wire logic                          accept,
    input  wire logic [dms_pkg::NOW_W-1:0]     now_ms,
    output logic                               due
);

    logic [dms_pkg::PERIOD_W-1:0] period_reg;
    logic [dms_pkg::NOW_W-1:0]    stamp_reg;
    logic [dms_pkg::NOW_W-1:0]    elapsed;

    // modulo 2^32 elapsed time
    assign elapsed = now_ms - stamp_reg;
    assign due     = elapsed >= {{(dms_pkg::NOW_W-dms_pkg::PERIOD_W){1'b0}}, period_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            stamp_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_data;
            end
            if (accept && due)
            begin
                stamp_reg <= now_ms;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/diagnostic_mode_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// diagnostic_mode_scheduler_top
// Picks the diagnostic measurement mode for each control-loop iteration.
// ----------------------------------------------------------------------------
// Usage:
//   req : one transaction per loop iteration, carrying now_ms.
//   rsp : one transaction per request: mode (0 current, 1 voltage,
//         2 temperature), voltage_due and temp_due.
//   cfg : writes the voltage period (index 0) or the temperature period
//         (index 1), in ms; always ready, write only while no request is
//         in flight.
// Response: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while responses are taken. The per-cycle figure is set by the
//   insertion chain through the QUEUE_DEPTH queue cells plus the two 32-bit
//   subtract-compare timers, all resolved in the accepting cycle.
// Stall: the response sits in an output register; a new request is taken
//   in the same cycle the held response is taken, so a stalled receiver
//   holds off req.ready only while the register is full and not drained.
// Reset: mode current, queue empty, stamps zero, periods 100 and 1000 ms.
//   No clearing pass; the block is ready as soon as reset releases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module diagnostic_mode_scheduler_top #(
    parameter int QUEUE_DEPTH = dms_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dms_req_if.sink     req,
    dms_rsp_if.source   rsp,
    dms_cfg_if.sink     cfg
);

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic accept;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Timers
    // ------------------------------------------------------------------
    logic v_due;
    logic t_due;
    logic cfg_we;

    assign cfg_we = cfg.valid && cfg.ready;

    dms_timer #(
        .PERIOD_RST (dms_pkg::VOLTAGE_PERIOD_RST)
    ) u_vtimer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we && cfg.index == dms_pkg::REG_VOLTAGE_PERIOD),
        .cfg_data (cfg.data),
        .accept   (accept),
        .now_ms   (req.now_ms),
        .due      (v_due)
    );

    dms_timer #(
        .PERIOD_RST (dms_pkg::TEMP_PERIOD_RST)
    ) u_ttimer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we && cfg.index == dms_pkg::REG_TEMP_PERIOD),
        .cfg_data (cfg.data),
        .accept   (accept),
        .now_ms   (req.now_ms),
        .due      (t_due)
    );

    // ------------------------------------------------------------------
    // Pending queue: row of cells. Insertion status flows left to right,
    // shifted values flow right to left on a pop.
    // ------------------------------------------------------------------
    dms_pkg::mode_t  mode_reg;
    dms_pkg::mode_t  mode_next;
    logic            pop;
    dms_pkg::chain_t link [0:QUEUE_DEPTH];
    dms_pkg::mode_t  post [0:QUEUE_DEPTH];
    dms_pkg::mode_t  entry [0:QUEUE_DEPTH-1];
    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] v_hit;

    assign pop               = (mode_reg == dms_pkg::MODE_CURRENT);
    assign link[0]           = '{v_done: 1'b0, t_done: 1'b0};
    assign post[QUEUE_DEPTH] = dms_pkg::MODE_CURRENT;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        dms_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (accept),
            .pop       (pop),
            .v_req     (v_due),
            .t_req     (t_due),
            .chain_in  (link[i]),
            .chain_out (link[i+1]),
            .right_val (post[i+1]),
            .post_val  (post[i]),
            .entry     (entry[i])
        );
        assign occ[i]   = (entry[i] != dms_pkg::MODE_CURRENT);
        assign v_hit[i] = (entry[i] == dms_pkg::MODE_VOLTAGE);
    end

    // current alternates with the queued modes
    assign mode_next = pop ? post[0] : dms_pkg::MODE_CURRENT;

    // ------------------------------------------------------------------
    // Mode and output register
    // ------------------------------------------------------------------
    logic [dms_pkg::MODE_W-1:0] rsp_mode_reg;
    logic                       rsp_vdue_reg;
    logic                       rsp_tdue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= dms_pkg::MODE_CURRENT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_mode_reg <= mode_next;
            rsp_vdue_reg <= v_due;
            rsp_tdue_reg <= t_due;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.mode        = rsp_mode_reg;
    assign rsp.voltage_due = rsp_vdue_reg;
    assign rsp.temp_due    = rsp_tdue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a non-current mode lasts exactly one transaction
    `DMS_ASSERT(a_mode_returns, clk, rst_n, (accept && !pop) |=> pop)
    // occupied slots form a prefix of the queue
    `DMS_ASSERT_ALWAYS(a_queue_compact, clk, ((occ + QUEUE_DEPTH'(1)) & occ) == '0)
    // dedupe keeps at most one voltage request queued
    `DMS_ASSERT_ALWAYS(a_no_dup_voltage, clk, $countones(v_hit) <= 1)
    // a response only appears after a request was taken
    `DMS_ASSERT(a_rsp_from_req, clk, rst_n, $rose(out_valid_reg) |-> $past(accept))

endmodule

`default_nettype wire
